// File: hdl/cst_pkg.sv
// Shared types, constants and codes for the calibrated sensor threshold block.
package cst_pkg;

    localparam int unsigned CHANNELS_DEF = 20;
    localparam int unsigned CMD_W        = 3;
    localparam int unsigned CHAN_W       = 5;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned HIT_MAP_W    = 20;
    localparam int unsigned HIT_COUNT_W  = 5;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [BYTE_W-1:0]      BYTE_MAX  = 8'd255;
    localparam logic [HIT_COUNT_W-1:0] COUNT_MAX = 5'd31;

    // span / 5 as (span * 205) >> 10, exact for any 8-bit span
    localparam logic [BYTE_W-1:0] DIV_RECIP = 8'd205;
    localparam int unsigned       DIV_SHIFT = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_CAL_RESET  = 3'd0,
        CMD_CAL_SAMPLE = 3'd1,
        CMD_FINISH     = 3'd2,
        CMD_LOAD       = 3'd3,
        CMD_CLASSIFY   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAL_RESET,
        OP_CAL_SAMPLE,
        OP_FINISH,
        OP_LOAD,
        OP_CLASSIFY
    } t_op;

    // Classified item handed from the front to the back
    typedef struct packed {
        t_op               op;
        logic              in_range;
        logic [CHAN_W-1:0] channel;
        logic [BYTE_W-1:0] sample;
    } t_task;

    typedef struct packed {
        logic [HIT_MAP_W-1:0]   hit_map;
        logic [HIT_COUNT_W-1:0] hit_count;
        logic                   above;
        logic [BYTE_W-1:0]      level;
    } t_result;

endpackage

// File: hdl/cst_if.sv
// Valid/ready channel interfaces for sensor items and threshold results.
interface cst_in_if import cst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] sample;

    modport source (output valid, output cmd, output channel, output sample, input ready);
    modport sink   (input valid, input cmd, input channel, input sample, output ready);
endinterface

interface cst_out_if import cst_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [HIT_MAP_W-1:0]   hit_map;
    logic [HIT_COUNT_W-1:0] hit_count;
    logic                   above;
    logic [BYTE_W-1:0]      level;

    modport source (output valid, output hit_map, output hit_count, output above,
                    output level, input ready);
    modport sink   (input valid, input hit_map, input hit_count, input above,
                    input level, output ready);
endinterface

// File: hdl/cst_queue.sv
// Short queue of classified items between the front and the back.
module cst_queue import cst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_task o_task
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_task              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_task  = r_slot[r_rd_ptr];

    // wrap pointers at the depth
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hdl/cst_front.sv
// Front end: accept sensor beats, decode the command and check the channel range.
module cst_front import cst_pkg::*; #(
    parameter int unsigned CHANNELS = CHANNELS_DEF
) (
    cst_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_task  o_task
);

    logic in_range;
    t_op  op;

    assign in_range = (32'(i_in.channel) < CHANNELS);

    // calibration reset acts on every channel; other commands drop when out of range
    always_comb begin
        unique case (i_in.cmd)
            CMD_CAL_RESET:  op = OP_CAL_RESET;
            CMD_CAL_SAMPLE: op = in_range ? OP_CAL_SAMPLE : OP_NONE;
            CMD_FINISH:     op = in_range ? OP_FINISH : OP_NONE;
            CMD_LOAD:       op = in_range ? OP_LOAD : OP_NONE;
            CMD_CLASSIFY:   op = in_range ? OP_CLASSIFY : OP_NONE;
            default:        op = OP_NONE;
        endcase
    end

    assign i_in.ready       = !i_full;
    assign o_push           = i_in.valid && !i_full;
    assign o_task.op        = op;
    assign o_task.in_range  = in_range;
    assign o_task.channel   = i_in.channel;
    assign o_task.sample    = i_in.sample;

endmodule

// File: hdl/cst_back.sv
// Back end: per-channel calibration tables, scan map and the result register.
module cst_back import cst_pkg::*; #(
    parameter int unsigned CHANNELS = CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_task       i_task,
    output logic        o_pop,
    cst_out_if.source   o_out
);

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned VIS_W = (CHANNELS > HIT_MAP_W) ? CHANNELS : HIT_MAP_W;
    localparam int unsigned PROD_W = 2 * BYTE_W;

    logic [BYTE_W-1:0]      r_low   [CHANNELS];
    logic [BYTE_W-1:0]      r_high  [CHANNELS];
    logic [BYTE_W-1:0]      r_cut   [CHANNELS];
    logic [CHANNELS-1:0]    r_map;
    logic [HIT_COUNT_W-1:0] r_count;
    logic                   r_out_valid;
    t_result                r_out;

    logic [IDX_W-1:0]       idx;
    logic [BYTE_W-1:0]      low;
    logic [BYTE_W-1:0]      high;
    logic [BYTE_W-1:0]      cut;
    logic [BYTE_W-1:0]      span;
    logic [PROD_W-1:0]      prod;
    logic [BYTE_W-1:0]      fin_level;
    logic                   go;
    logic                   new_scan;
    logic [CHANNELS-1:0]    n_map;
    logic [HIT_COUNT_W-1:0] n_count;
    logic                   n_above;
    logic [BYTE_W-1:0]      n_level;
    logic [VIS_W-1:0]       map_ext;
    t_result                n_out;

    assign idx  = i_task.channel[IDX_W-1:0];
    assign low  = r_low[idx];
    assign high = r_high[idx];
    assign cut  = r_cut[idx];

    // threshold = min + ((max - min) mod 256) / 5, wrapping
    assign span      = high - low;
    assign prod      = PROD_W'(span) * PROD_W'(DIV_RECIP);
    assign fin_level = low + BYTE_W'(prod >> DIV_SHIFT);

    // advance when the result register is free or being drained
    assign go    = i_valid && (!r_out_valid || o_out.ready);
    assign o_pop = go;

    assign new_scan = (i_task.op == OP_CLASSIFY) && (i_task.channel == '0);
    assign n_above  = (i_task.op == OP_CLASSIFY) && (i_task.sample > cut);

    always_comb begin
        n_map   = new_scan ? '0 : r_map;
        n_count = new_scan ? '0 : r_count;
        // count a channel only the first time it is seen above in a scan
        if (n_above && !n_map[idx]) begin
            n_map[idx] = 1'b1;
            if (n_count != COUNT_MAX) begin
                n_count = n_count + 1'b1;
            end
        end
    end

    always_comb begin
        if (!i_task.in_range) begin
            n_level = '0;
        end else begin
            case (i_task.op)
                OP_FINISH: n_level = fin_level;
                OP_LOAD:   n_level = i_task.sample;
                default:   n_level = cut;
            endcase
        end
    end

    assign map_ext         = VIS_W'(n_map);
    assign n_out.hit_map   = map_ext[HIT_MAP_W-1:0];
    assign n_out.hit_count = n_count;
    assign n_out.above     = n_above;
    assign n_out.level     = n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_low[c]  <= BYTE_MAX;
                r_high[c] <= '0;
                r_cut[c]  <= '0;
            end
            r_map       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                case (i_task.op)
                    OP_CAL_RESET: begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_low[c]  <= BYTE_MAX;
                            r_high[c] <= '0;
                        end
                    end
                    OP_CAL_SAMPLE: begin
                        if (i_task.sample > high) begin
                            r_high[idx] <= i_task.sample;
                        end
                        if (i_task.sample < low) begin
                            r_low[idx] <= i_task.sample;
                        end
                    end
                    OP_FINISH: r_cut[idx] <= fin_level;
                    OP_LOAD:   r_cut[idx] <= i_task.sample;
                    OP_CLASSIFY: begin
                        r_map   <= n_map;
                        r_count <= n_count;
                    end
                    default: ;
                endcase
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.hit_map   = r_out.hit_map;
    assign o_out.hit_count = r_out.hit_count;
    assign o_out.above     = r_out.above;
    assign o_out.level     = r_out.level;

endmodule

// File: hdl/calibrated_sensor_array_threshold_core.sv
// Top level of the calibrated sensor array threshold core.
// Takes one command beat per clock for a scanned array of 8-bit light sensors
// and returns exactly one result beat per command, in order. Per channel the
// core keeps the lowest and highest calibration reading and an 8-bit threshold
// (min + span/5 on finish, or a direct load); classify beats compare a reading
// with its channel's threshold and build the hit map and hit count of the
// current scan, which a classify on channel 0 restarts. Throughput is one beat
// per cycle, sustained with the output held by a stalling sink only as long as
// the two-entry queue absorbs it. The beat lands in the queue at its accepting
// edge, and the back end, which reads, updates and writes the addressed channel's
// table entries as it takes the beat, then registers its result, so each beat
// sees everything earlier beats left. All tables sit in flip-flops cleared by
// reset, so the core is ready the cycle after reset drops.
module calibrated_sensor_array_threshold_core import cst_pkg::*; #(
    parameter int unsigned CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cst_in_if.sink     i_in,
    cst_out_if.source  o_out
);

    // front -> queue
    logic  push;
    logic  full;
    t_task front_task;

    // queue -> back
    logic  pop;
    logic  queue_valid;
    t_task queue_task;

    // accept and classify; hold off only when the queue is full
    cst_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_task (front_task)
    );

    // decouple the two sides so a stalled sink does not stall the source at once
    cst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (front_task),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_task  (queue_task)
    );

    // execute against the tables and register the result beat
    cst_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_task  (queue_task),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// File: verif/cst_threshold_sb_pkg.sv
// Scoreboard class that predicts and checks the sensor threshold core's result beats.
package cst_threshold_sb_pkg;
    import cst_pkg::*;

    localparam int unsigned SPAN_DIVISOR = 5;
    localparam int unsigned REPORT_LIMIT = 10;

    class threshold_scoreboard;
        logic [BYTE_W-1:0]      cal_min [CHANNELS_DEF];
        logic [BYTE_W-1:0]      cal_max [CHANNELS_DEF];
        logic [BYTE_W-1:0]      cut [CHANNELS_DEF];
        logic [31:0]            scan_bits;
        logic [HIT_COUNT_W-1:0] scan_hits;
        t_result                pending_q [$];
        int unsigned            mismatches;
        int unsigned            results_seen;

        function new();
            clear_calibration();
            foreach (cut[c]) cut[c] = '0;
            scan_bits    = '0;
            scan_hits    = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void clear_calibration();
            foreach (cal_min[c]) begin
                cal_min[c] = BYTE_MAX;
                cal_max[c] = '0;
            end
        endfunction

        function logic [BYTE_W-1:0] threshold_of(logic [CHAN_W-1:0] ch);
            return (ch < CHANNELS_DEF) ? cut[ch] : '0;
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction

        // Apply one accepted command beat and queue the result it must produce.
        function void note_command(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                                   logic [BYTE_W-1:0] smp);
            t_result            exp;
            logic               in_range;
            logic [BYTE_W-1:0]  span;
            exp      = '0;
            in_range = (ch < CHANNELS_DEF);
            if (cmd == CMD_CAL_RESET) begin
                clear_calibration();
            end else if (in_range) begin
                case (cmd)
                    CMD_CAL_SAMPLE: begin
                        if (smp > cal_max[ch]) cal_max[ch] = smp;
                        if (smp < cal_min[ch]) cal_min[ch] = smp;
                    end
                    CMD_FINISH: begin
                        span    = cal_max[ch] - cal_min[ch];
                        cut[ch] = cal_min[ch] + BYTE_W'(span / SPAN_DIVISOR);
                    end
                    CMD_LOAD: cut[ch] = smp;
                    CMD_CLASSIFY: begin
                        if (ch == 0) begin
                            scan_bits = '0;
                            scan_hits = '0;
                        end
                        if (smp > cut[ch]) begin
                            exp.above = 1'b1;
                            if (!scan_bits[ch]) begin
                                scan_bits[ch] = 1'b1;
                                if (scan_hits != COUNT_MAX) scan_hits++;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (in_range) exp.level = cut[ch];
            exp.hit_map   = scan_bits[HIT_MAP_W-1:0];
            exp.hit_count = scan_hits;
            pending_q.push_back(exp);
        endfunction

        // Compare one accepted result beat with the oldest queued expectation.
        function void check_result(t_result got);
            t_result exp;
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result beat %0d arrived with nothing pending: map=%05h count=%0d",
                             results_seen, got.hit_map, got.hit_count);
                return;
            end
            exp = pending_q.pop_front();
            if (got.hit_map !== exp.hit_map || got.hit_count !== exp.hit_count ||
                got.above !== exp.above || got.level !== exp.level) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result beat %0d: expected map=%05h count=%0d above=%0b level=%0d,",
                              " got map=%05h count=%0d above=%0b level=%0d"},
                             results_seen, exp.hit_map, exp.hit_count, exp.above, exp.level,
                             got.hit_map, got.hit_count, got.above, got.level);
            end
        endfunction
    endclass

endpackage

// File: verif/calibrated_sensor_array_threshold_core_test.sv
// Self-checking bench for the calibrated sensor array threshold core.
module calibrated_sensor_array_threshold_core_test;
    import cst_pkg::*;
    import cst_threshold_sb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RESET_CYCLES    = 11;
    localparam int unsigned ITEMS_PER_PHASE = 412;
    localparam int unsigned PHASES          = 4;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned SETTLE_CYCLES   = 12;
    localparam int unsigned LIMIT_CYCLES    = 200000;

    // Command codes the core does not define; they must leave state alone.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;

    cst_in_if  in_if ();
    cst_out_if out_if ();

    calibrated_sensor_array_threshold_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    threshold_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request   = 0;
    int unsigned useful_beats   = 0;
    int unsigned cycle_count    = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the results never drain.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Result side: check every accepted beat, then pick ready for the next cycle.
    // A long hold-off requested by the stimulus is counted down here, cycle by cycle.
    initial begin : result_sink
        t_result     got;
        int unsigned hold_left;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.hit_map   = out_if.hit_map;
                got.hit_count = out_if.hit_count;
                got.above     = out_if.above;
                got.level     = out_if.level;
                sb.check_result(got);
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one command beat, idling at random first, and hold it until accepted.
    // Valid stays high on return so back-to-back beats need no gap.
    task automatic offer_item(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                              logic [BYTE_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.cmd     <= cmd;
        in_if.channel <= ch;
        in_if.sample  <= smp;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_command(cmd, ch, smp);
        // Beats the core simply ignores do not count toward the item budget.
        if (cmd == CMD_CAL_RESET || (ch < CHANNELS_DEF && cmd <= CMD_CLASSIFY))
            useful_beats++;
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Reading biased toward the edges of the byte range.
    function automatic logic [BYTE_W-1:0] pick_reading();
        case ($urandom_range(7))
            0:       return '0;
            1:       return BYTE_MAX;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // Reading within a few counts of the channel's current threshold, clamped.
    function automatic logic [BYTE_W-1:0] near_threshold(logic [CHAN_W-1:0] ch);
        int v;
        v = int'(sb.threshold_of(ch)) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return BYTE_W'(v);
    endfunction

    // Calibration pass: clear, sample a few channels, finish them. A channel
    // finished with no samples exercises the wrapped min-above-max case.
    task automatic calibration_round();
        int unsigned       chans;
        int unsigned       reads;
        logic [CHAN_W-1:0] ch;
        offer_item(CMD_CAL_RESET, CHAN_W'($urandom_range(31)), BYTE_W'($urandom_range(255)));
        chans = $urandom_range(1, 6);
        repeat (chans) begin
            ch    = CHAN_W'($urandom_range(CHANNELS_DEF - 1));
            reads = $urandom_range(0, 4);
            repeat (reads) offer_item(CMD_CAL_SAMPLE, ch, pick_reading());
            offer_item(CMD_FINISH, ch, BYTE_W'($urandom_range(255)));
        end
    endtask

    // Full scan in channel order, with the odd skipped or repeated channel and
    // now and then no channel 0, so the map carries over from the last scan.
    task automatic scan_round();
        logic [CHAN_W-1:0] ch;
        int unsigned       first;
        first = ($urandom_range(9) == 0) ? 1 : 0;
        for (int c = first; c < CHANNELS_DEF; c++) begin
            ch = CHAN_W'(c);
            if ($urandom_range(9) == 0) continue;
            if ($urandom_range(3) == 0)
                offer_item(CMD_CLASSIFY, ch, pick_reading());
            else
                offer_item(CMD_CLASSIFY, ch, near_threshold(ch));
            if ($urandom_range(9) == 0)
                offer_item(CMD_CLASSIFY, ch, pick_reading());
        end
    endtask

    task automatic random_round();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            calibration_round();
        end else if (pick < 40) begin
            repeat ($urandom_range(1, 4))
                offer_item(CMD_LOAD, CHAN_W'($urandom_range(CHANNELS_DEF - 1)), pick_reading());
        end else if (pick < 85) begin
            scan_round();
        end else begin
            // Noise: any command, any channel, including unused codes and
            // channels past the end of the array.
            repeat ($urandom_range(1, 3))
                offer_item(CMD_W'($urandom_range(7)), CHAN_W'($urandom_range(31)),
                           BYTE_W'($urandom_range(255)));
        end
    endtask

    initial begin : stimulus
        int unsigned target;
        in_if.valid   <= 1'b0;
        in_if.cmd     <= CMD_CAL_RESET;
        in_if.channel <= '0;
        in_if.sample  <= '0;
        i_rst_n       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats over the corner cases, idling off.
        offer_item(CMD_CLASSIFY, 5'd0, 8'd0);          // new scan, reading equals threshold
        offer_item(CMD_CLASSIFY, 5'd1, BYTE_MAX);      // above
        offer_item(CMD_CLASSIFY, 5'd1, 8'd200);        // repeated channel, not recounted
        offer_item(CMD_FINISH, 5'd2, 8'd0);            // finish with no samples wraps to 255
        offer_item(CMD_CLASSIFY, 5'd2, BYTE_MAX);      // equal is not above
        offer_item(CMD_CAL_SAMPLE, 5'd3, 8'd0);
        offer_item(CMD_CAL_SAMPLE, 5'd3, BYTE_MAX);
        offer_item(CMD_FINISH, 5'd3, 8'd0);            // 0 + 255/5
        offer_item(CMD_CLASSIFY, 5'd3, 8'd52);
        offer_item(CMD_CLASSIFY, 5'd3, 8'd51);
        offer_item(CMD_LOAD, 5'd19, BYTE_MAX);
        offer_item(CMD_CLASSIFY, 5'd19, BYTE_MAX);
        offer_item(CMD_LOAD, 5'd19, 8'd0);
        offer_item(CMD_CLASSIFY, 5'd19, 8'd1);         // top map bit
        offer_item(CMD_CAL_RESET, 5'd31, 8'd170);      // clears every channel, any index
        offer_item(CMD_FINISH, 5'd3, 8'd85);           // finish right after clear
        offer_item(CMD_CLASSIFY, 5'd20, BYTE_MAX);     // past the array: no effect
        offer_item(CMD_LOAD, 5'd31, BYTE_MAX);
        offer_item(CMD_CAL_SAMPLE, 5'd24, 8'd0);
        offer_item(CMD_SPARE_LO, 5'd4, 8'd85);         // unused codes
        offer_item(CMD_SPARE_MID, 5'd10, BYTE_MAX);
        offer_item(CMD_SPARE_HI, 5'd0, 8'd0);          // channel 0 but no new scan
        offer_item(CMD_CLASSIFY, 5'd0, BYTE_MAX);      // new scan, above
        drain_results();

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            // Back-pressure the core while beats keep coming so its queue fills.
            if (phase == 0) hold_request = HOLD_CYCLES;
            target = useful_beats + ITEMS_PER_PHASE;
            while (useful_beats < target) random_round();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/cst_pkg.sv
hdl/cst_if.sv
hdl/cst_queue.sv
hdl/cst_front.sv
hdl/cst_back.sv
hdl/calibrated_sensor_array_threshold_core.sv
verif/cst_threshold_sb_pkg.sv
verif/calibrated_sensor_array_threshold_core_test.sv
